// ----- hdl/sorted_priority_queue_defines.svh -----
// Assertion macros shared by the queue modules.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define SPQ_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- hdl/spq_pkg.sv -----
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int PRI_W    = 16;
   localparam int TAG_W    = 32;
   localparam int STAT_W   = 2;
   localparam int FILL_W   = 5;

   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the request fields
      logic insert;   // insert the captured entry in order
      logic remove;   // pop the front entry
      logic respond;  // register the response fields
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic func;
      logic full;
      logic empty;
   } stat_type;

endpackage

// ----- hdl/sorted_priority_queue.sv -----
// Channel   | Ports                                          | Handshake
// request   | req_func, req_priority_req, req_tag            | start high while busy is low
// response  | rsp_status, rsp_out_priority, rsp_out_tag,     | rsp_valid for one cycle
//           | rsp_fill                                       |
//
// Each beat passes through capture, execute and response in turn. The next start is taken
// the cycle after the response strobe. All cells compare against the new priority at
// once, so insert and remove each finish within the execute state.
// Reset is synchronous and clears the fill count and controller; the entry cells are
// not cleared, since only cells below the fill count are ever read.
// The receiver cannot stall: each response is shown for exactly one cycle.
module sorted_priority_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic signed [spq_pkg::PRI_W-1:0]    req_priority_req,
   input  logic        [spq_pkg::TAG_W-1:0]    req_tag,
   output logic                                rsp_valid,
   output logic        [spq_pkg::STAT_W-1:0]   rsp_status,
   output logic signed [spq_pkg::PRI_W-1:0]    rsp_out_priority,
   output logic        [spq_pkg::TAG_W-1:0]    rsp_out_tag,
   output logic        [spq_pkg::FILL_W-1:0]   rsp_fill
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_priority_req (req_priority_req),
      .req_tag          (req_tag),
      .rsp_status       (rsp_status),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_fill         (rsp_fill)
   );

endmodule

// ----- hdl/spq_ctrl.sv -----
`include "sorted_priority_queue_defines.svh"

module spq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   input  spq_pkg::stat_type  stat,
   output spq_pkg::cmd_type   cmd
);
   import spq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.insert  = (stat.func == FUNC_ENQ) && !stat.full;
            cmd.remove  = (stat.func == FUNC_DEQ) && !stat.empty;
            cmd.respond = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   `SPQ_ASSERT(a_accept_exec, clock, reset, (start && !busy) |=> (state_ff == S_EXEC), "accepted beat did not reach execute")
   `SPQ_ASSERT(a_resp_single, clock, reset, rsp_valid |=> !rsp_valid, "response strobe held longer than one cycle")
   `SPQ_ASSERT_NEVER(a_ins_rem, clock, reset, cmd.insert && cmd.remove, "insert and remove issued together")

endmodule

// ----- hdl/spq_datapath.sv -----
`include "sorted_priority_queue_defines.svh"

module spq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  spq_pkg::cmd_type                    cmd,
   output spq_pkg::stat_type                   stat,
   input  logic                                req_func,
   input  logic signed [spq_pkg::PRI_W-1:0]    req_priority_req,
   input  logic        [spq_pkg::TAG_W-1:0]    req_tag,
   output logic        [spq_pkg::STAT_W-1:0]   rsp_status,
   output logic signed [spq_pkg::PRI_W-1:0]    rsp_out_priority,
   output logic        [spq_pkg::TAG_W-1:0]    rsp_out_tag,
   output logic        [spq_pkg::FILL_W-1:0]   rsp_fill
);
   import spq_pkg::*;

   // Captured request.
   logic                    func_ff;
   logic signed [PRI_W-1:0] pri_ff;
   logic        [TAG_W-1:0] tag_ff;

   // Sorted entry cells, front entry in cell 0.
   logic signed [PRI_W-1:0] ent_pri_ff [CAPACITY];
   logic        [TAG_W-1:0] ent_tag_ff [CAPACITY];
   logic signed [PRI_W-1:0] ent_pri_in [CAPACITY];
   logic        [TAG_W-1:0] ent_tag_in [CAPACITY];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic [STAT_W-1:0]       status_ff;
   logic signed [PRI_W-1:0] opri_ff;
   logic [TAG_W-1:0]        otag_ff;

   // A cell stays put when it holds an entry of greater or equal priority.
   // Because the cells are sorted, these flags form a prefix.
   logic [CAPACITY-1:0] keep;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         keep[i] = (CNT_W'(i) < count_ff) && (ent_pri_ff[i] >= pri_ff);
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [PRI_W-1:0] ins_pri;
      logic        [TAG_W-1:0] ins_tag;
      logic signed [PRI_W-1:0] up_pri;
      logic        [TAG_W-1:0] up_tag;

      if (g == 0) begin : g_head
         assign ins_pri = pri_ff;
         assign ins_tag = tag_ff;
      end else begin : g_body
         assign ins_pri = keep[g-1] ? pri_ff : ent_pri_ff[g-1];
         assign ins_tag = keep[g-1] ? tag_ff : ent_tag_ff[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign up_pri = ent_pri_ff[g];
         assign up_tag = ent_tag_ff[g];
      end else begin : g_mid
         assign up_pri = ent_pri_ff[g+1];
         assign up_tag = ent_tag_ff[g+1];
      end

      always_comb begin
         ent_pri_in[g] = ent_pri_ff[g];
         ent_tag_in[g] = ent_tag_ff[g];
         if (cmd.insert && !keep[g]) begin
            ent_pri_in[g] = ins_pri;
            ent_tag_in[g] = ins_tag;
         end else if (cmd.remove) begin
            ent_pri_in[g] = up_pri;
            ent_tag_in[g] = up_tag;
         end
      end

      always_ff @(posedge clock) begin
         ent_pri_ff[g] <= ent_pri_in[g];
         ent_tag_ff[g] <= ent_tag_in[g];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         pri_ff  <= req_priority_req;
         tag_ff  <= req_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         if (cmd.insert || cmd.remove) begin
            status_ff <= STAT_OK;
         end else if (func_ff == FUNC_ENQ) begin
            status_ff <= STAT_FULL;
         end else begin
            status_ff <= STAT_EMPTY;
         end
         opri_ff <= cmd.remove ? ent_pri_ff[0] : '0;
         otag_ff <= cmd.remove ? ent_tag_ff[0] : '0;
      end
   end

   assign stat.func  = func_ff;
   assign stat.full  = (count_ff == CNT_W'(CAPACITY));
   assign stat.empty = (count_ff == '0);

   assign rsp_status       = status_ff;
   assign rsp_out_priority = opri_ff;
   assign rsp_out_tag      = otag_ff;
   assign rsp_fill         = FILL_W'(count_ff);

   `SPQ_ASSERT_NEVER(a_count_max, clock, reset, count_ff > CNT_W'(CAPACITY), "fill count beyond capacity")
   `SPQ_ASSERT(a_insert_grow, clock, reset, cmd.insert |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)), "insert did not grow the queue")
   `SPQ_ASSERT(a_remove_shrink, clock, reset, cmd.remove |=> (count_ff == CNT_W'($past(count_ff) - 1'b1)), "remove did not shrink the queue")

endmodule

// ----- tb/tb_sorted_priority_queue.sv -----
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int CLK_PERIOD   = 20;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1250;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic signed [PRI_W-1:0] pri;
      logic [TAG_W-1:0]        tag;
      logic [FILL_W-1:0]       fill;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic req_func;
   logic signed [PRI_W-1:0] req_priority_req;
   logic [TAG_W-1:0]        req_tag;
   logic                    rsp_valid;
   logic [STAT_W-1:0]       rsp_status;
   logic signed [PRI_W-1:0] rsp_out_priority;
   logic [TAG_W-1:0]        rsp_out_tag;
   logic [FILL_W-1:0]       rsp_fill;

   // Shadow copy of the queue contents, front entry in slot 0.
   logic signed [PRI_W-1:0] shadow_pri [CAPACITY];
   logic [TAG_W-1:0]        shadow_tag [CAPACITY];
   int                      shadow_count = 0;
   queue_result_type        pending_results [$];

   int mismatch_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   sorted_priority_queue DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_priority_req (req_priority_req),
      .req_tag          (req_tag),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_fill         (rsp_fill)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void model_queue_op(input logic func,
                                          input logic signed [PRI_W-1:0] pri,
                                          input logic [TAG_W-1:0] tag);
      queue_result_type res;
      int slot;
      res = '0;
      res.status = STAT_OK;
      if (func == FUNC_ENQ) begin
         if (shadow_count >= CAPACITY) begin
            res.status = STAT_FULL;
         end else begin
            // New entry goes behind every entry of greater or equal priority.
            slot = 0;
            while (slot < shadow_count && shadow_pri[slot] >= pri) slot++;
            for (int i = shadow_count; i > slot; i--) begin
               shadow_pri[i] = shadow_pri[i-1];
               shadow_tag[i] = shadow_tag[i-1];
            end
            shadow_pri[slot] = pri;
            shadow_tag[slot] = tag;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = STAT_EMPTY;
         end else begin
            res.pri = shadow_pri[0];
            res.tag = shadow_tag[0];
            for (int i = 1; i < shadow_count; i++) begin
               shadow_pri[i-1] = shadow_pri[i];
               shadow_tag[i-1] = shadow_tag[i];
            end
            shadow_count--;
         end
      end
      res.fill = FILL_W'(shadow_count);
      pending_results.push_back(res);
   endfunction

   function automatic logic signed [PRI_W-1:0] pick_priority();
      case ($urandom_range(0, 3))
         0: return PRI_W'(int'($urandom_range(0, 6)) - 3);
         1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: return PRI_W'($urandom());
      endcase
   endfunction

   // Sends one beat, then closes the burst with a random gap, which may be zero, when it runs out.
   task automatic send_beat(input logic func, input logic signed [PRI_W-1:0] pri,
                            input logic [TAG_W-1:0] tag);
      int gap;
      req_func         <= func;
      req_priority_req <= pri;
      req_tag          <= tag;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      model_queue_op(func, pri, tag);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic report_field(input string field, input logic [TAG_W-1:0] want,
                               input logic [TAG_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_response
      queue_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response beat with nothing expected, actual status %0d",
                     $time, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            report_field("status", TAG_W'(want.status), TAG_W'(rsp_status));
            report_field("out_priority", TAG_W'(unsigned'(want.pri)),
                         TAG_W'(unsigned'(rsp_out_priority)));
            report_field("out_tag", want.tag, rsp_out_tag);
            report_field("fill", TAG_W'(want.fill), TAG_W'(rsp_fill));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("sorted_priority_queue verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_dequeue_empty();
      send_beat(FUNC_DEQ, 16'sh7FFF, 32'hFFFF_FFFF);
      send_beat(FUNC_DEQ, 16'sh8000, 32'h0000_0000);
   endtask

   // Extreme priorities plus a pair of equal priorities that must leave in order.
   task automatic test_priority_extremes();
      send_beat(FUNC_ENQ, 16'sh8000, 32'h0000_0000);
      send_beat(FUNC_ENQ, 16'sh0005, 32'hAAAA_AAAA);
      send_beat(FUNC_ENQ, 16'sh7FFF, 32'hFFFF_FFFF);
      send_beat(FUNC_ENQ, 16'sh0005, 32'h5555_5555);
      repeat (4) send_beat(FUNC_DEQ, '0, '0);
   endtask

   task automatic test_fill_to_capacity();
      logic signed [PRI_W-1:0] pri;
      for (int i = 0; i < CAPACITY; i++) begin
         case (i % 4)
            0: pri = 16'sh7FFF;
            1: pri = 16'sh8000;
            2: pri = 16'sh0000;
            default: pri = -16'sd1;
         endcase
         send_beat(FUNC_ENQ, pri, (i % 2) ? (32'hFFFF_FFF0 | i) : TAG_W'(i));
      end
      // The queue is full now, so this one must be refused.
      send_beat(FUNC_ENQ, 16'sh7FFF, 32'hFFFF_FFFF);
   endtask

   // Phases lean toward filling, mixing or draining so that both the full and
   // the empty boundary are visited many times.
   task automatic test_random_traffic();
      int   enq_pct;
      logic func;
      enq_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: enq_pct = 85;
               1: enq_pct = 50;
               default: enq_pct = 15;
            endcase
         end
         func = ($urandom_range(1, 100) <= enq_pct) ? FUNC_ENQ : FUNC_DEQ;
         send_beat(func, pick_priority(), $urandom());
      end
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_func         <= FUNC_ENQ;
      req_priority_req <= '0;
      req_tag          <= '0;
      burst_left = $urandom_range(1, 8);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_dequeue_empty();
      test_priority_extremes();
      test_fill_to_capacity();
      test_random_traffic();

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("sorted_priority_queue verification clean");
      end else begin
         $display("sorted_priority_queue verification failed");
      end
      $finish;
   end

endmodule

// ----- sorted_priority_queue.f -----
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue.sv
tb/tb_sorted_priority_queue.sv
